FILE: src/sgs_pkg.sv
// ----------------------------------------------------------------------------
// sgs_pkg: shared types and constants for the servo gesture slew sequencer
// Gesture codes, register indexes, field widths and the draw table used to
// reduce raw random words to lo + raw mod span.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int TIME_W  = 32;   // millisecond timestamps
  localparam int RAW_W   = 31;   // raw random words
  localparam int IVL_W   = 16;   // step interval registers
  localparam int ANGLE_W = 8;
  localparam int CFG_W   = 16;   // widest register
  localparam int IDX_W   = 2;

  // Reciprocal reduction: quotient estimate is (raw * floor(2^RAW_W / span)) >> RAW_W,
  // which is the true quotient or one less, so the remainder estimate is below
  // twice the span and fits in RED_W bits.
  localparam int RCP_W  = 26;
  localparam int RED_W  = 14;
  localparam int DRAW_W = 14;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_ANSWER   = 3'd1,
    MODE_SAD      = 3'd2,
    MODE_HAPPY    = 3'd3,
    MODE_STANDBY  = 3'd4,
    MODE_WAKE_NOD = 3'd5,
    MODE_THINKING = 3'd6,
    MODE_SWEEP    = 3'd7
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE       = 2'd0,
    REG_STEP_IVL   = 2'd1,
    REG_ANSWER_IVL = 2'd2,
    REG_SAD_IVL    = 2'd3
  } reg_idx_t;

  localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(20);

  localparam logic [ANGLE_W-1:0] CENTRE   = ANGLE_W'(90);
  localparam logic [ANGLE_W-1:0] SWAY_HI  = ANGLE_W'(110);
  localparam logic [ANGLE_W-1:0] SWAY_LO  = ANGLE_W'(80);
  localparam logic [ANGLE_W-1:0] NOD_UP   = ANGLE_W'(120);
  localparam logic [ANGLE_W-1:0] NOD_DOWN = ANGLE_W'(60);
  localparam logic [TIME_W-1:0]  NOD_DWELL_MS = TIME_W'(1000);

  typedef struct packed {
    logic [DRAW_W-1:0] lo;
    logic [RED_W-1:0]  span;
    logic [RCP_W-1:0]  rcp;
  } draw_cfg_t;

  localparam logic [RCP_W-1:0] RCP_5001 = RCP_W'((64'd1 << RAW_W) / 64'd5001);
  localparam logic [RCP_W-1:0] RCP_3001 = RCP_W'((64'd1 << RAW_W) / 64'd3001);
  localparam logic [RCP_W-1:0] RCP_2001 = RCP_W'((64'd1 << RAW_W) / 64'd2001);
  localparam logic [RCP_W-1:0] RCP_1001 = RCP_W'((64'd1 << RAW_W) / 64'd1001);
  localparam logic [RCP_W-1:0] RCP_181  = RCP_W'((64'd1 << RAW_W) / 64'd181);
  localparam logic [RCP_W-1:0] RCP_121  = RCP_W'((64'd1 << RAW_W) / 64'd121);
  localparam logic [RCP_W-1:0] RCP_91   = RCP_W'((64'd1 << RAW_W) / 64'd91);
  localparam logic [RCP_W-1:0] RCP_61   = RCP_W'((64'd1 << RAW_W) / 64'd61);

  localparam draw_cfg_t DC_5000_10001 = '{DRAW_W'(5000), RED_W'(5001), RCP_5001};
  localparam draw_cfg_t DC_7000_10001 = '{DRAW_W'(7000), RED_W'(3001), RCP_3001};
  localparam draw_cfg_t DC_2000_3001  = '{DRAW_W'(2000), RED_W'(1001), RCP_1001};
  localparam draw_cfg_t DC_1000_2001  = '{DRAW_W'(1000), RED_W'(1001), RCP_1001};
  localparam draw_cfg_t DC_3000_5001  = '{DRAW_W'(3000), RED_W'(2001), RCP_2001};
  localparam draw_cfg_t DC_45_136     = '{DRAW_W'(45),   RED_W'(91),   RCP_91};
  localparam draw_cfg_t DC_60_121     = '{DRAW_W'(60),   RED_W'(61),   RCP_61};
  localparam draw_cfg_t DC_30_151     = '{DRAW_W'(30),   RED_W'(121),  RCP_121};
  localparam draw_cfg_t DC_0_181      = '{DRAW_W'(0),    RED_W'(181),  RCP_181};

  // Move-delay draw per gesture; gestures other than idle and answer share the default entry.
  function automatic draw_cfg_t dly_cfg(mode_t m);
    draw_cfg_t c;
    unique case (m)
      MODE_IDLE:   c = DC_5000_10001;
      MODE_ANSWER: c = DC_7000_10001;
      default:     c = DC_2000_3001;
    endcase
    return c;
  endfunction

  function automatic draw_cfg_t tgt_cfg(mode_t m);
    draw_cfg_t c;
    unique case (m)
      MODE_IDLE:     c = DC_45_136;
      MODE_THINKING: c = DC_30_151;
      MODE_SWEEP:    c = DC_0_181;
      default:       c = DC_60_121;
    endcase
    return c;
  endfunction

  function automatic draw_cfg_t dwl_cfg(mode_t m);
    draw_cfg_t c;
    unique case (m)
      MODE_IDLE:     c = DC_2000_3001;
      MODE_THINKING: c = DC_3000_5001;
      MODE_SWEEP:    c = DC_3000_5001;
      default:       c = DC_1000_2001;
    endcase
    return c;
  endfunction

endpackage

FILE: src/sgs_draw.sv
// ----------------------------------------------------------------------------
// sgs_draw: random draw reduction
// Two register stages turning a raw word into lo + raw mod span: a reciprocal
// multiply for the quotient estimate, then a narrow multiply-subtract and one
// correcting subtract.
// ----------------------------------------------------------------------------
module sgs_draw import sgs_pkg::*; (
  input  logic              clk,
  input  logic              load_mul,
  input  logic              load_red,
  input  logic [RAW_W-1:0]  raw,
  input  draw_cfg_t         cfg,
  output logic [DRAW_W-1:0] draw
);

  logic [RAW_W+RCP_W-1:0] prod;
  logic [RCP_W-1:0]       quo;
  logic [RED_W-1:0]       raw_lo;
  logic [2*RED_W-1:0]     qd;
  logic [RED_W-1:0]       rem_est;
  logic [RED_W-1:0]       rem;
  logic [DRAW_W-1:0]      draw_next;

  assign prod = {{RCP_W{1'b0}}, raw} * {{RAW_W{1'b0}}, cfg.rcp};

  always_ff @(posedge clk) begin
    if (load_mul) begin
      quo    <= prod[RAW_W+RCP_W-1:RAW_W];
      raw_lo <= raw[RED_W-1:0];
    end
  end

  // remainder estimate lies in [0, 2*span), so low bits are enough
  always_comb begin
    qd        = {{RED_W{1'b0}}, quo[RED_W-1:0]} * {{RED_W{1'b0}}, cfg.span};
    rem_est   = raw_lo - qd[RED_W-1:0];
    rem       = (rem_est >= cfg.span) ? rem_est - cfg.span : rem_est;
    draw_next = cfg.lo + DRAW_W'(rem);
  end

  always_ff @(posedge clk) begin
    if (load_red) begin
      draw <= draw_next;
    end
  end

endmodule

FILE: src/servo_gesture_slew_sequencer.sv
// ----------------------------------------------------------------------------
// servo_gesture_slew_sequencer: gesture-driven servo slew per time tick
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   tick     | tick_valid / tick_stall   | now_ms, rand_delay_raw,
//            |                           | rand_target_raw, rand_dwell_raw
//   result   | result_valid/result_stall | angle, write_strobe
//   config   | cfg_write                 | cfg_index, cfg_data
//
// One beat per clock while the result side is not stalled; a result beat
// passes through four registers: input register, reciprocal multiply,
// draw reduction, then the state update into the result register.
// The state update is the only stage that touches gesture state, so ticks
// stream back to back. Each stage holds while the one after it is full and
// stalled. Reset (rst, synchronous) sets position and target to centre, clears
// flags and timestamps, and loads mode 0 with 20 ms intervals.
// ----------------------------------------------------------------------------
module servo_gesture_slew_sequencer import sgs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               tick_valid,
  output logic               tick_stall,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [RAW_W-1:0]   rand_delay_raw,
  input  logic [RAW_W-1:0]   rand_target_raw,
  input  logic [RAW_W-1:0]   rand_dwell_raw,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [ANGLE_W-1:0] angle,
  output logic               write_strobe
);

  // configuration
  mode_t             mode;
  logic [IVL_W-1:0]  step_ivl;
  logic [IVL_W-1:0]  answer_ivl;
  logic [IVL_W-1:0]  sad_ivl;

  // pipeline control
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic ld1, ld2, ld3, adv;

  logic [TIME_W-1:0] now1, now2, now3;
  logic [RAW_W-1:0]  dly_raw1, tgt_raw1, dwl_raw1;
  logic [DRAW_W-1:0] dly_draw, tgt_draw, dwl_draw;

  // gesture state
  logic [ANGLE_W-1:0] position, target;
  logic               waiting, returning, sway_high;
  logic [TIME_W-1:0]  last_step_time, last_move_time, dwell_start_time;

  logic [ANGLE_W-1:0] position_next, target_next;
  logic               waiting_next, returning_next, sway_high_next;
  logic [TIME_W-1:0]  last_step_time_next, last_move_time_next, dwell_start_time_next;
  logic               moved_next;

  assign rdy_out = !result_valid || !result_stall;
  assign rdy3    = !v3 || rdy_out;
  assign rdy2    = !v2 || rdy3;
  assign rdy1    = !v1 || rdy2;
  assign ld1     = tick_valid && rdy1;
  assign ld2     = v1 && rdy2;
  assign ld3     = v2 && rdy3;
  assign adv     = v3 && rdy_out;
  assign tick_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      step_ivl   <= IVL_RESET;
      answer_ivl <= IVL_RESET;
      sad_ivl    <= IVL_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:       mode       <= mode_t'(cfg_data[2:0]);
        REG_STEP_IVL:   step_ivl   <= cfg_data[IVL_W-1:0];
        REG_ANSWER_IVL: answer_ivl <= cfg_data[IVL_W-1:0];
        REG_SAD_IVL:    sad_ivl    <= cfg_data[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v1           <= ld1 || (v1 && !rdy2);
      v2           <= ld2 || (v2 && !rdy3);
      v3           <= ld3 || (v3 && !rdy_out);
      result_valid <= adv || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      now1     <= now_ms;
      dly_raw1 <= rand_delay_raw;
      tgt_raw1 <= rand_target_raw;
      dwl_raw1 <= rand_dwell_raw;
    end
    if (ld2) begin
      now2 <= now1;
    end
    if (ld3) begin
      now3 <= now2;
    end
  end

  sgs_draw u_dly (
    .clk      (clk),
    .load_mul (ld2),
    .load_red (ld3),
    .raw      (dly_raw1),
    .cfg      (dly_cfg(mode)),
    .draw     (dly_draw)
  );

  sgs_draw u_tgt (
    .clk      (clk),
    .load_mul (ld2),
    .load_red (ld3),
    .raw      (tgt_raw1),
    .cfg      (tgt_cfg(mode)),
    .draw     (tgt_draw)
  );

  sgs_draw u_dwl (
    .clk      (clk),
    .load_mul (ld2),
    .load_red (ld3),
    .raw      (dwl_raw1),
    .cfg      (dwl_cfg(mode)),
    .draw     (dwl_draw)
  );

  function automatic logic [ANGLE_W-1:0] step_pos(logic [ANGLE_W-1:0] p,
                                                   logic [ANGLE_W-1:0] t);
    return (p < t) ? p + ANGLE_W'(1) : p - ANGLE_W'(1);
  endfunction

  always_comb begin
    logic [ANGLE_W-1:0] pos, tgt;
    logic               wt, rt, sh, mv;
    logic [TIME_W-1:0]  lst, lmt, dst;
    logic [IVL_W-1:0]   gate;

    pos = position;
    tgt = target;
    wt  = waiting;
    rt  = returning;
    sh  = sway_high;
    lst = last_step_time;
    lmt = last_move_time;
    dst = dwell_start_time;
    mv  = 1'b0;

    case (mode) inside
      MODE_ANSWER, MODE_HAPPY: gate = answer_ivl;
      MODE_SAD:                gate = sad_ivl;
      default:                 gate = step_ivl;
    endcase

    if (now3 - lst >= TIME_W'(gate)) begin
      lst = now3;
      case (mode) inside
        MODE_IDLE, MODE_ANSWER, MODE_SAD, MODE_HAPPY: begin
          if (!wt && !rt && (now3 - lmt >= TIME_W'(dly_draw))) begin
            if (mode == MODE_SAD) begin
              tgt = sh ? SWAY_HI : SWAY_LO;
              sh  = !sh;
            end else begin
              tgt = tgt_draw[ANGLE_W-1:0];
            end
            lmt = now3;
          end
          if (pos != tgt && !wt && !rt) begin
            mv  = 1'b1;
            pos = step_pos(pos, tgt);
            if (pos == tgt) begin
              wt  = 1'b1;
              dst = now3;
            end
          end else if (wt && (now3 - dst >= TIME_W'(dwl_draw))) begin
            wt  = 1'b0;
            rt  = 1'b1;
            tgt = CENTRE;
          end else if (rt && pos != tgt) begin
            mv  = 1'b1;
            pos = step_pos(pos, tgt);
            if (pos == tgt) begin
              rt  = 1'b0;
              lmt = now3;
            end
          end
        end
        MODE_STANDBY: begin
          if (pos != CENTRE) begin
            pos = step_pos(pos, CENTRE);
            mv  = 1'b1;
          end
        end
        MODE_WAKE_NOD: begin
          if (!wt && !rt && pos == CENTRE && tgt == CENTRE &&
              (now3 - lmt >= TIME_W'(dly_draw))) begin
            tgt = NOD_UP;
            lmt = now3;
          end
          if (pos != tgt && !wt && !rt) begin
            mv  = 1'b1;
            pos = step_pos(pos, tgt);
            if (pos == tgt) begin
              wt  = 1'b1;
              dst = now3;
            end
          end else if (wt && (now3 - dst >= NOD_DWELL_MS)) begin
            wt = 1'b0;
            // a target other than up or down is left alone
            if (tgt == NOD_UP) begin
              tgt = NOD_DOWN;
            end else if (tgt == NOD_DOWN) begin
              tgt = CENTRE;
              rt  = 1'b1;
            end
            lmt = now3;
          end else if (rt && pos != tgt) begin
            mv  = 1'b1;
            pos = step_pos(pos, tgt);
            if (pos == tgt) begin
              rt  = 1'b0;
              lmt = now3;
            end
          end
        end
        default: begin
          if (wt && (now3 - dst >= TIME_W'(dwl_draw))) begin
            wt  = 1'b0;
            tgt = tgt_draw[ANGLE_W-1:0];
            lmt = now3;
          end
          if (!wt && pos == tgt) begin
            wt  = 1'b1;
            dst = now3;
          end
          if (pos != tgt && !wt) begin
            mv  = 1'b1;
            pos = step_pos(pos, tgt);
            if (pos == tgt) begin
              wt  = 1'b1;
              dst = now3;
              lmt = now3;
            end
          end
        end
      endcase
    end

    position_next         = pos;
    target_next           = tgt;
    waiting_next          = wt;
    returning_next        = rt;
    sway_high_next        = sh;
    last_step_time_next   = lst;
    last_move_time_next   = lmt;
    dwell_start_time_next = dst;
    moved_next            = mv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= CENTRE;
      target           <= CENTRE;
      waiting          <= 1'b0;
      returning        <= 1'b0;
      sway_high        <= 1'b0;
      last_step_time   <= '0;
      last_move_time   <= '0;
      dwell_start_time <= '0;
    end else if (adv) begin
      position         <= position_next;
      target           <= target_next;
      waiting          <= waiting_next;
      returning        <= returning_next;
      sway_high        <= sway_high_next;
      last_step_time   <= last_step_time_next;
      last_move_time   <= last_move_time_next;
      dwell_start_time <= dwell_start_time_next;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (adv) begin
      angle        <= position_next;
      write_strobe <= moved_next;
    end
  end

endmodule
